@@ rtl/core/m4mul_pkg.sv @@
// Shared constants, operation codes and controller/datapath types for the
// 4x4 fixed-point matrix multiplier. No dependencies.
package m4mul_pkg;

    localparam int DIM       = 4;
    localparam int FRAC_BITS = 16;
    localparam int CELLS     = DIM * DIM;
    localparam int K_W       = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int E_W       = $clog2(CELLS);
    localparam int VAL_W     = 32;
    localparam int IDX_W     = 4;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int ACC_W     = PROD_W + K_W;

    typedef enum logic [1:0] {
        OP_WR_A    = 2'd0,
        OP_WR_B    = 2'd1,
        OP_COMPUTE = 2'd2
    } t_op;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic           wr_a;
        logic           wr_b;
        logic [E_W-1:0] wr_idx;
        logic           issue;
        logic           first;
        logic           last_k;
        logic [K_W-1:0] k;
        logic [K_W-1:0] row;
        logic [K_W-1:0] col;
    } t_dp_cmd;

    // Status from the datapath back to the controller
    typedef struct packed {
        logic pipe_active;
    } t_dp_status;

endpackage

@@ rtl/core/m4mul_ctrl.sv @@
// Controller for the matrix multiplier: decodes words, sequences the
// column/row/k loop of a compute. Depends on m4mul_pkg.
module m4mul_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_op,
    input  logic [m4mul_pkg::IDX_W-1:0] i_elem_index,
    input  m4mul_pkg::t_dp_status     i_status,
    output m4mul_pkg::t_dp_cmd        o_cmd
);
    import m4mul_pkg::*;

    typedef enum logic {S_IDLE, S_RUN} t_state;

    localparam logic [K_W-1:0] K_LAST = K_W'(DIM - 1);

    t_state         r_state, n_state;
    logic [K_W-1:0] r_k, n_k;
    logic [K_W-1:0] r_row, n_row;
    logic [K_W-1:0] r_col, n_col;
    logic           accept;
    logic           idx_ok;

    assign busy   = (r_state == S_RUN) || i_status.pipe_active;
    assign accept = start && !busy;
    assign idx_ok = int'(i_elem_index) < CELLS;

    // Decode load words straight into store writes
    always_comb begin
        o_cmd        = '0;
        o_cmd.wr_idx = E_W'(i_elem_index);
        if (accept && idx_ok) begin
            case (i_op)
                OP_WR_A: o_cmd.wr_a = 1'b1;
                OP_WR_B: o_cmd.wr_b = 1'b1;
                default: ;
            endcase
        end
        o_cmd.issue  = (r_state == S_RUN);
        o_cmd.first  = (r_k == '0);
        o_cmd.last_k = (r_k == K_LAST);
        o_cmd.k      = r_k;
        o_cmd.row    = r_row;
        o_cmd.col    = r_col;
    end

    // Advance the loop counters: k innermost, then row, then column
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_row   = r_row;
        n_col   = r_col;
        case (r_state)
            S_IDLE: begin
                if (accept && i_op == OP_COMPUTE) begin
                    n_state = S_RUN;
                    n_k     = '0;
                    n_row   = '0;
                    n_col   = '0;
                end
            end
            S_RUN: begin
                if (r_k == K_LAST) begin
                    n_k = '0;
                    if (r_row == K_LAST) begin
                        n_row = '0;
                        if (r_col == K_LAST) begin
                            n_col   = '0;
                            n_state = S_IDLE;
                        end else begin
                            n_col = r_col + 1'b1;
                        end
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_row   <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_row   <= n_row;
            r_col   <= n_col;
        end
    end

    // Final step of the loop returns to idle
    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_k == K_LAST && r_row == K_LAST && r_col == K_LAST)
        |=> (r_state == S_IDLE))
        else $error("compute loop did not end after last element");

    // No store write while a compute is sequencing
    a_no_write_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> !(o_cmd.wr_a || o_cmd.wr_b))
        else $error("store write during compute");

endmodule

@@ rtl/core/m4mul_dp.sv @@
// Datapath for the matrix multiplier: A and B stores, one signed multiplier,
// wide accumulator, shift and saturate. Depends on m4mul_pkg.
module m4mul_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  m4mul_pkg::t_dp_cmd            i_cmd,
    input  logic signed [m4mul_pkg::VAL_W-1:0] i_elem_value,
    output m4mul_pkg::t_dp_status         o_status,
    output logic                          o_valid,
    output logic [m4mul_pkg::IDX_W-1:0]   o_out_index,
    output logic signed [m4mul_pkg::VAL_W-1:0] o_out_value,
    output logic                          o_saturated,
    output logic                          o_last
);
    import m4mul_pkg::*;

    localparam logic [E_W-1:0] POS_LAST = E_W'(CELLS - 1);

    logic signed [VAL_W-1:0]  r_a [CELLS];
    logic signed [VAL_W-1:0]  r_b [CELLS];
    logic [E_W-1:0]           a_addr, b_addr, pos;
    logic signed [VAL_W-1:0]  a_op, b_op;
    logic signed [PROD_W-1:0] n_prod;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_p_v, r_p_first, r_p_last;
    logic [E_W-1:0]           r_p_pos;

    logic signed [ACC_W-1:0]  r_acc, n_acc, prod_ext;
    logic                     r_a_v;
    logic [E_W-1:0]           r_a_pos;

    logic signed [ACC_W-1:0]  shifted;
    logic [ACC_W-VAL_W:0]     hi_bits;
    logic                     n_sat;
    logic signed [VAL_W-1:0]  n_value;

    // Write the element stores
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CELLS; i++) begin
                r_a[i] <= '0;
                r_b[i] <= '0;
            end
        end else begin
            if (i_cmd.wr_a) r_a[i_cmd.wr_idx] <= i_elem_value;
            if (i_cmd.wr_b) r_b[i_cmd.wr_idx] <= i_elem_value;
        end
    end

    // Select operands A[k][row] and B[col][k], multiply
    assign a_addr = E_W'(int'(i_cmd.k) * DIM + int'(i_cmd.row));
    assign b_addr = E_W'(int'(i_cmd.col) * DIM + int'(i_cmd.k));
    assign pos    = E_W'(int'(i_cmd.col) * DIM + int'(i_cmd.row));
    assign a_op   = r_a[a_addr];
    assign b_op   = r_b[b_addr];
    assign n_prod = a_op * b_op;

    // Product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else begin
            r_p_v <= i_cmd.issue;
        end
        r_prod    <= n_prod;
        r_p_first <= i_cmd.first;
        r_p_last  <= i_cmd.last_k;
        r_p_pos   <= pos;
    end

    // Accumulate products, restart on the first term of each element
    assign prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign n_acc    = r_p_first ? prod_ext : r_acc + prod_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else begin
            r_a_v <= r_p_v && r_p_last;
        end
        if (r_p_v) begin
            r_acc   <= n_acc;
            r_a_pos <= r_p_pos;
        end
    end

    // Drop fraction bits, clip to the 32-bit range
    assign shifted = r_acc >>> FRAC_BITS;
    assign hi_bits = shifted[ACC_W-1:VAL_W-1];
    assign n_sat   = !((&hi_bits) || (~|hi_bits));
    assign n_value = n_sat ? (shifted[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}}
                                               : {1'b0, {(VAL_W-1){1'b1}}})
                           : shifted[VAL_W-1:0];

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_a_v;
        end
        o_out_index <= IDX_W'(r_a_pos);
        o_out_value <= n_value;
        o_saturated <= n_sat;
        o_last      <= (r_a_pos == POS_LAST);
    end

    assign o_status.pipe_active = r_p_v || r_a_v;

    // A finished sum always shows up on the outputs next cycle
    a_sum_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_v |=> o_valid)
        else $error("finished sum not emitted");

    // Last marker only on the final position
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_out_index == IDX_W'(CELLS - 1)))
        else $error("last marker on wrong position");

    // Clipped values are the range limits
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
        (o_out_value == {1'b0, {(VAL_W-1){1'b1}}} ||
         o_out_value == {1'b1, {(VAL_W-1){1'b0}}}))
        else $error("saturated value is not a range limit");

endmodule

@@ rtl/core/matrix4_multiply.sv @@
// 4x4 signed Q16.16 matrix multiplier, column-major, R = A * B.
// Load words write one element each. A compute word runs on one shared
// 32x32 multiplier (four products per element); each result passes the
// product, accumulator and output registers; busy holds off new words.
// The receiver cannot stall. Synchronous active-low reset clears both stores.
// Depends on m4mul_pkg, m4mul_ctrl, m4mul_dp.
module matrix4_multiply (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_op,
    input  logic [m4mul_pkg::IDX_W-1:0]   i_elem_index,
    input  logic signed [m4mul_pkg::VAL_W-1:0] i_elem_value,
    output logic                          o_valid,
    output logic [m4mul_pkg::IDX_W-1:0]   o_out_index,
    output logic signed [m4mul_pkg::VAL_W-1:0] o_out_value,
    output logic                          o_saturated,
    output logic                          o_last
);
    import m4mul_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // Sequence words and the compute loop
    m4mul_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_op         (i_op),
        .i_elem_index (i_elem_index),
        .i_status     (status),
        .o_cmd        (cmd)
    );

    // Stores, multiply-accumulate and result register
    m4mul_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_elem_value (i_elem_value),
        .o_status     (status),
        .o_valid      (o_valid),
        .o_out_index  (o_out_index),
        .o_out_value  (o_out_value),
        .o_saturated  (o_saturated),
        .o_last       (o_last)
    );

endmodule
